// ----- rtl/core/i2cmbs_pkg.sv -----
package i2cmbs_pkg;

    // Command codes carried in the op field
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4,
        OP_WAIT  = 3'd5,
        OP_ACK   = 3'd6,
        OP_NACK  = 3'd7
    } op_t;

    // Phase within the running command
    typedef enum logic [1:0] {
        PHASE_FIRST  = 2'd0,
        PHASE_SECOND = 2'd1,
        PHASE_THIRD  = 2'd2,
        PHASE_STOP   = 2'd3
    } phase_t;

    localparam logic [15:0] TIMEOUT_RESET = 16'(16 * 250);
    localparam logic [15:0] WAIT_MAX      = 16'hFFFF;
    localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

endpackage

// ----- rtl/core/i2c_master_bit_sequencer_unit.sv -----
// I2C master pin sequencer, one bus delay tick per request.
// Input stream: each request is one tick carrying a command (taken only while
// no command runs), the byte to send and the sampled SDA level. Output stream:
// one result per request with SCL, SDA level, SDA drive enable, busy, done,
// the last read byte and the missing-ACK flag.
// The result of a request accepted at one edge is presented from the next edge
// on, held in the output register. Throughput is one request per cycle while the
// receiver takes results; the sequencer state advances in the same cycle as the
// request is taken, so the only loop is one tick of the phase logic.
// s_axis_tready is high while the output register is empty or being taken; a
// stalled receiver holds the result and blocks new requests, and no request is
// lost or repeated.
// Reset (aresetn low, synchronous) returns to idle with SCL and SDA high and
// driven, clears the read byte and the flag, empties the output register and
// loads the ACK timeout limit with 4000. cfg_wr_en writes the limit at once.
// Start, stop, ack and nack take 2 to 3 ticks, write 24, read 16, and wait-ACK
// at least 3 ticks plus one per high SDA sample.
module i2c_master_bit_sequencer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: ack_timeout_limit
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] op, [10:3] tx_byte, [11] sda_in, [15:12] zero
    input  logic [i2cmbs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] scl, [1] sda_out, [2] sda_drive, [3] busy_res, [4] done_res,
    // [12:5] rx_byte, [13] ack_missing, [15:14] zero
    output logic [i2cmbs_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // State registers
    i2cmbs_pkg::op_t    cmd_reg, cmd_next;
    i2cmbs_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  bit_cnt_reg, bit_cnt_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] wait_reg, wait_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        drv_reg, drv_next;
    logic [7:0]  rx_reg, rx_next;
    logic        ack_miss_reg, ack_miss_next;
    logic [15:0] limit_reg;

    // Output register
    logic        out_valid_reg;
    logic [i2cmbs_pkg::OUT_TDATA_W-1:0] out_data_reg;

    // Request fields and per-tick work signals
    i2cmbs_pkg::op_t    in_op;
    logic [7:0]  in_tx;
    logic        in_sda;
    logic        accept;
    logic        busy;
    logic        fin;
    logic [3:0]  bit_inc;
    logic [15:0] wait_inc;
    i2cmbs_pkg::op_t    eff_cmd;
    i2cmbs_pkg::phase_t eff_phase;
    logic [3:0]  eff_bit_cnt;
    logic [7:0]  eff_shift;
    logic [15:0] eff_wait;

    assign in_op  = i2cmbs_pkg::op_t'(s_axis_tdata[2:0]);
    assign in_tx  = s_axis_tdata[10:3];
    assign in_sda = s_axis_tdata[11];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Latch a new command only while idle
    always_comb begin
        if (cmd_reg == i2cmbs_pkg::OP_NONE && in_op != i2cmbs_pkg::OP_NONE) begin
            eff_cmd     = in_op;
            eff_phase   = i2cmbs_pkg::PHASE_FIRST;
            eff_bit_cnt = 4'd0;
            eff_wait    = 16'd0;
            eff_shift   = (in_op == i2cmbs_pkg::OP_WRITE) ? in_tx : 8'd0;
        end else begin
            eff_cmd     = cmd_reg;
            eff_phase   = phase_reg;
            eff_bit_cnt = bit_cnt_reg;
            eff_wait    = wait_reg;
            eff_shift   = shift_reg;
        end
    end

    assign bit_inc  = eff_bit_cnt + 4'd1;
    assign wait_inc = (eff_wait != i2cmbs_pkg::WAIT_MAX) ? eff_wait + 16'd1 : eff_wait;

    // Advance one phase of the running command
    always_comb begin
        cmd_next      = eff_cmd;
        phase_next    = eff_phase;
        bit_cnt_next  = eff_bit_cnt;
        shift_next    = eff_shift;
        wait_next     = eff_wait;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        drv_next      = drv_reg;
        rx_next       = rx_reg;
        ack_miss_next = ack_miss_reg;
        fin           = 1'b0;
        busy          = (eff_cmd != i2cmbs_pkg::OP_NONE);

        unique case (eff_cmd)
            i2cmbs_pkg::OP_NONE: begin
            end
            i2cmbs_pkg::OP_START: begin
                if (eff_phase == i2cmbs_pkg::PHASE_FIRST) begin
                    drv_next   = 1'b1;
                    sda_next   = 1'b1;
                    scl_next   = 1'b1;
                    phase_next = i2cmbs_pkg::PHASE_SECOND;
                end else if (eff_phase == i2cmbs_pkg::PHASE_SECOND) begin
                    sda_next   = 1'b0;
                    phase_next = i2cmbs_pkg::PHASE_THIRD;
                end else begin
                    scl_next = 1'b0;
                    fin      = 1'b1;
                end
            end
            i2cmbs_pkg::OP_STOP: begin
                if (eff_phase == i2cmbs_pkg::PHASE_FIRST) begin
                    drv_next   = 1'b1;
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                    phase_next = i2cmbs_pkg::PHASE_SECOND;
                end else begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                    fin      = 1'b1;
                end
            end
            i2cmbs_pkg::OP_WRITE: begin
                if (eff_phase == i2cmbs_pkg::PHASE_FIRST) begin
                    drv_next   = 1'b1;
                    scl_next   = 1'b0;
                    sda_next   = eff_shift[7];
                    phase_next = i2cmbs_pkg::PHASE_SECOND;
                end else if (eff_phase == i2cmbs_pkg::PHASE_SECOND) begin
                    scl_next   = 1'b1;
                    phase_next = i2cmbs_pkg::PHASE_THIRD;
                end else begin
                    scl_next     = 1'b0;
                    shift_next   = {eff_shift[6:0], 1'b0};
                    bit_cnt_next = bit_inc;
                    if (bit_inc >= i2cmbs_pkg::BITS_PER_BYTE) begin
                        fin = 1'b1;
                    end else begin
                        phase_next = i2cmbs_pkg::PHASE_FIRST;
                    end
                end
            end
            i2cmbs_pkg::OP_READ: begin
                if (eff_phase == i2cmbs_pkg::PHASE_FIRST) begin
                    drv_next   = 1'b0;
                    scl_next   = 1'b0;
                    phase_next = i2cmbs_pkg::PHASE_SECOND;
                end else begin
                    scl_next     = 1'b1;
                    shift_next   = {eff_shift[6:0], in_sda};
                    bit_cnt_next = bit_inc;
                    if (bit_inc >= i2cmbs_pkg::BITS_PER_BYTE) begin
                        rx_next = {eff_shift[6:0], in_sda};
                        fin     = 1'b1;
                    end else begin
                        phase_next = i2cmbs_pkg::PHASE_FIRST;
                    end
                end
            end
            i2cmbs_pkg::OP_WAIT: begin
                if (eff_phase == i2cmbs_pkg::PHASE_FIRST) begin
                    drv_next   = 1'b1;
                    sda_next   = 1'b1;
                    phase_next = i2cmbs_pkg::PHASE_SECOND;
                end else if (eff_phase == i2cmbs_pkg::PHASE_SECOND) begin
                    scl_next   = 1'b1;
                    phase_next = i2cmbs_pkg::PHASE_THIRD;
                end else if (eff_phase == i2cmbs_pkg::PHASE_THIRD) begin
                    drv_next = 1'b0;
                    if (!in_sda) begin
                        scl_next      = 1'b0;
                        ack_miss_next = 1'b0;
                        fin           = 1'b1;
                    end else begin
                        wait_next = wait_inc;
                        // Give up: emit the first stop tick now
                        if (wait_inc > limit_reg) begin
                            drv_next   = 1'b1;
                            scl_next   = 1'b0;
                            sda_next   = 1'b0;
                            phase_next = i2cmbs_pkg::PHASE_STOP;
                        end
                    end
                end else begin
                    drv_next      = 1'b1;
                    scl_next      = 1'b1;
                    sda_next      = 1'b1;
                    ack_miss_next = 1'b1;
                    fin           = 1'b1;
                end
            end
            i2cmbs_pkg::OP_ACK, i2cmbs_pkg::OP_NACK: begin
                if (eff_phase == i2cmbs_pkg::PHASE_FIRST) begin
                    scl_next   = 1'b0;
                    drv_next   = 1'b1;
                    sda_next   = (eff_cmd == i2cmbs_pkg::OP_NACK);
                    phase_next = i2cmbs_pkg::PHASE_SECOND;
                end else if (eff_phase == i2cmbs_pkg::PHASE_SECOND) begin
                    scl_next   = 1'b1;
                    phase_next = i2cmbs_pkg::PHASE_THIRD;
                end else begin
                    scl_next = 1'b0;
                    fin      = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // Drop back to idle on the last tick
        if (fin) begin
            cmd_next   = i2cmbs_pkg::OP_NONE;
            phase_next = i2cmbs_pkg::PHASE_FIRST;
        end
    end

    // Hold sequencer state; advance on each accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg      <= i2cmbs_pkg::OP_NONE;
            phase_reg    <= i2cmbs_pkg::PHASE_FIRST;
            bit_cnt_reg  <= 4'd0;
            shift_reg    <= 8'd0;
            wait_reg     <= 16'd0;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
            drv_reg      <= 1'b1;
            rx_reg       <= 8'd0;
            ack_miss_reg <= 1'b0;
        end else if (accept) begin
            cmd_reg      <= cmd_next;
            phase_reg    <= phase_next;
            bit_cnt_reg  <= bit_cnt_next;
            shift_reg    <= shift_next;
            wait_reg     <= wait_next;
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
            drv_reg      <= drv_next;
            rx_reg       <= rx_next;
            ack_miss_reg <= ack_miss_next;
        end
    end

    // Write the timeout limit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= i2cmbs_pkg::TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    // Output register: load on accept, empty when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= {2'b00, ack_miss_next, rx_next, fin, busy,
                             drv_next, sda_next, scl_next};
        end
    end

    // Idle command state always sits in the first phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_reg == i2cmbs_pkg::OP_NONE |-> phase_reg == i2cmbs_pkg::PHASE_FIRST)
        else $error("idle sequencer not in first phase");

    // Bit counter never passes one byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        bit_cnt_reg <= i2cmbs_pkg::BITS_PER_BYTE)
        else $error("bit counter overran");

    // An idle request with no command reports not busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && cmd_reg == i2cmbs_pkg::OP_NONE && in_op == i2cmbs_pkg::OP_NONE
        |=> m_axis_tvalid && !m_axis_tdata[3] && !m_axis_tdata[4])
        else $error("idle request reported busy or done");

    // A finished command leaves the sequencer idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && fin |=> cmd_reg == i2cmbs_pkg::OP_NONE)
        else $error("command still active after done");

endmodule

// ----- tb/testbench.sv -----
module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REQUEST_TARGET = 1600;

    // one result, packed as m_axis_tdata[13:0], scl in bit 0
    typedef struct packed {
        logic       ack_missing;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_drive;
        logic       sda_out;
        logic       scl;
    } pin_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [2:0] op, [10:3] tx_byte, [11] sda_in, [15:12] zero
    logic [i2cmbs_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [0] scl, [1] sda_out, [2] sda_drive, [3] busy_res, [4] done_res,
    // [12:5] rx_byte, [13] ack_missing, [15:14] zero
    logic [i2cmbs_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    i2c_master_bit_sequencer_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 aclk = ~aclk;

    // requests waiting to be sent and pin levels waiting to be seen
    logic [i2cmbs_pkg::IN_TDATA_W-1:0] pending_ticks[$];
    pin_result_t                       expected_pins[$];

    // sequencer mirror
    logic [15:0]        ack_limit   = i2cmbs_pkg::TIMEOUT_RESET;
    i2cmbs_pkg::op_t    cur_cmd     = i2cmbs_pkg::OP_NONE;
    i2cmbs_pkg::phase_t cur_phase   = i2cmbs_pkg::PHASE_FIRST;
    logic [3:0]         bit_cnt     = '0;
    logic [7:0]         shreg       = '0;
    logic [15:0]        poll_cnt    = '0;
    logic               pin_scl     = 1'b1;
    logic               pin_sda     = 1'b1;
    logic               pin_drv     = 1'b1;
    logic [7:0]         rx_hold     = '0;
    logic               ack_missing = 1'b0;

    int err_cnt       = 0;
    int stim_cnt      = 0;
    int req_cnt       = 0;
    int res_cnt       = 0;
    int timeouts_seen = 0;
    int reads_done    = 0;
    int limit_writes  = 0;
    int quiet_cycles  = 0;

    logic req_taken = 1'b0;
    logic res_taken = 1'b0;
    int   s_wait = 0;
    int   m_wait = 0;
    bit   s_calm = 1'b0;
    bit   m_calm = 1'b0;

    // advance the mirror by one tick and queue the pins it drives
    task automatic sequencer_tick(input i2cmbs_pkg::op_t op, input logic [7:0] tx,
                                  input logic sda);
        pin_result_t r;
        logic        fin;
        fin = 1'b0;
        r.busy_res = 1'b0;
        if (cur_cmd == i2cmbs_pkg::OP_NONE && op != i2cmbs_pkg::OP_NONE) begin
            cur_cmd   = op;
            cur_phase = i2cmbs_pkg::PHASE_FIRST;
            bit_cnt   = '0;
            poll_cnt  = '0;
            shreg     = (op == i2cmbs_pkg::OP_WRITE) ? tx : 8'h00;
        end
        if (cur_cmd != i2cmbs_pkg::OP_NONE) begin
            r.busy_res = 1'b1;
            case (cur_cmd)
                i2cmbs_pkg::OP_START: begin
                    if (cur_phase == i2cmbs_pkg::PHASE_FIRST) begin
                        pin_drv = 1'b1; pin_sda = 1'b1; pin_scl = 1'b1;
                        cur_phase = i2cmbs_pkg::PHASE_SECOND;
                    end else if (cur_phase == i2cmbs_pkg::PHASE_SECOND) begin
                        pin_sda = 1'b0;
                        cur_phase = i2cmbs_pkg::PHASE_THIRD;
                    end else begin
                        pin_scl = 1'b0;
                        fin = 1'b1;
                    end
                end
                i2cmbs_pkg::OP_STOP: begin
                    if (cur_phase == i2cmbs_pkg::PHASE_FIRST) begin
                        pin_drv = 1'b1; pin_scl = 1'b0; pin_sda = 1'b0;
                        cur_phase = i2cmbs_pkg::PHASE_SECOND;
                    end else begin
                        pin_scl = 1'b1; pin_sda = 1'b1;
                        fin = 1'b1;
                    end
                end
                i2cmbs_pkg::OP_WRITE: begin
                    if (cur_phase == i2cmbs_pkg::PHASE_FIRST) begin
                        pin_drv = 1'b1; pin_scl = 1'b0; pin_sda = shreg[7];
                        cur_phase = i2cmbs_pkg::PHASE_SECOND;
                    end else if (cur_phase == i2cmbs_pkg::PHASE_SECOND) begin
                        pin_scl = 1'b1;
                        cur_phase = i2cmbs_pkg::PHASE_THIRD;
                    end else begin
                        pin_scl = 1'b0;
                        shreg   = shreg << 1;
                        bit_cnt = bit_cnt + 4'd1;
                        if (bit_cnt >= i2cmbs_pkg::BITS_PER_BYTE) fin = 1'b1;
                        else cur_phase = i2cmbs_pkg::PHASE_FIRST;
                    end
                end
                i2cmbs_pkg::OP_READ: begin
                    if (cur_phase == i2cmbs_pkg::PHASE_FIRST) begin
                        pin_drv = 1'b0; pin_scl = 1'b0;
                        cur_phase = i2cmbs_pkg::PHASE_SECOND;
                    end else begin
                        pin_scl = 1'b1;
                        shreg   = {shreg[6:0], sda};
                        bit_cnt = bit_cnt + 4'd1;
                        if (bit_cnt >= i2cmbs_pkg::BITS_PER_BYTE) begin
                            rx_hold = shreg;
                            fin = 1'b1;
                            reads_done++;
                        end else begin
                            cur_phase = i2cmbs_pkg::PHASE_FIRST;
                        end
                    end
                end
                i2cmbs_pkg::OP_WAIT: begin
                    if (cur_phase == i2cmbs_pkg::PHASE_FIRST) begin
                        pin_drv = 1'b1; pin_sda = 1'b1;
                        cur_phase = i2cmbs_pkg::PHASE_SECOND;
                    end else if (cur_phase == i2cmbs_pkg::PHASE_SECOND) begin
                        pin_scl = 1'b1;
                        cur_phase = i2cmbs_pkg::PHASE_THIRD;
                    end else if (cur_phase == i2cmbs_pkg::PHASE_THIRD) begin
                        pin_drv = 1'b0;
                        if (!sda) begin
                            pin_scl = 1'b0; ack_missing = 1'b0;
                            fin = 1'b1;
                        end else begin
                            // saturate the poll count, give up past the limit
                            if (poll_cnt != i2cmbs_pkg::WAIT_MAX) poll_cnt = poll_cnt + 16'd1;
                            if (poll_cnt > ack_limit) begin
                                pin_drv = 1'b1; pin_scl = 1'b0; pin_sda = 1'b0;
                                cur_phase = i2cmbs_pkg::PHASE_STOP;
                            end
                        end
                    end else begin
                        pin_drv = 1'b1; pin_scl = 1'b1; pin_sda = 1'b1;
                        ack_missing = 1'b1;
                        fin = 1'b1;
                        timeouts_seen++;
                    end
                end
                default: begin
                    if (cur_phase == i2cmbs_pkg::PHASE_FIRST) begin
                        pin_scl = 1'b0; pin_drv = 1'b1;
                        pin_sda = (cur_cmd == i2cmbs_pkg::OP_NACK);
                        cur_phase = i2cmbs_pkg::PHASE_SECOND;
                    end else if (cur_phase == i2cmbs_pkg::PHASE_SECOND) begin
                        pin_scl = 1'b1;
                        cur_phase = i2cmbs_pkg::PHASE_THIRD;
                    end else begin
                        pin_scl = 1'b0;
                        fin = 1'b1;
                    end
                end
            endcase
            if (fin) begin
                cur_cmd   = i2cmbs_pkg::OP_NONE;
                cur_phase = i2cmbs_pkg::PHASE_FIRST;
            end
        end
        r.scl         = pin_scl;
        r.sda_out     = pin_sda;
        r.sda_drive   = pin_drv;
        r.done_res    = fin;
        r.rx_byte     = rx_hold;
        r.ack_missing = ack_missing;
        expected_pins.push_back(r);
    endtask

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
            err_cnt++;
        end
    endtask

    // sample both handshakes, predict on requests, check results
    always @(posedge aclk) begin : watch_ports
        pin_result_t got;
        pin_result_t want;
        req_taken <= aresetn && s_axis_tvalid && s_axis_tready;
        res_taken <= aresetn && m_axis_tvalid && m_axis_tready;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                req_cnt++;
                sequencer_tick(i2cmbs_pkg::op_t'(s_axis_tdata[2:0]), s_axis_tdata[10:3],
                               s_axis_tdata[11]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                res_cnt++;
                got = pin_result_t'(m_axis_tdata[13:0]);
                if (expected_pins.size() == 0) begin
                    $display("%0t: result %0h with no request pending", $time, m_axis_tdata);
                    err_cnt++;
                end else begin
                    want = expected_pins.pop_front();
                    check_field("scl", want.scl, got.scl);
                    check_field("sda_out", want.sda_out, got.sda_out);
                    check_field("sda_drive", want.sda_drive, got.sda_drive);
                    check_field("busy_res", want.busy_res, got.busy_res);
                    check_field("done_res", want.done_res, got.done_res);
                    check_field("rx_byte", want.rx_byte, got.rx_byte);
                    check_field("ack_missing", want.ack_missing, got.ack_missing);
                end
            end
            // end the run when the bus stops moving
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // present requests from the queue with random gaps
    always @(negedge aclk) begin : feed_requests
        logic                              nv;
        logic [i2cmbs_pkg::IN_TDATA_W-1:0] nd;
        nv = s_axis_tvalid;
        nd = s_axis_tdata;
        if (aresetn && (!s_axis_tvalid || req_taken)) begin
            nv = 1'b0;
            if (s_wait > 0) begin
                s_wait--;
            end else if (pending_ticks.size() > 0) begin
                nd = pending_ticks.pop_front();
                nv = 1'b1;
                if ($urandom_range(0, 99) < 2) s_calm = !s_calm;
                s_wait = s_calm ? 0 : $urandom_range(0, 10);
            end
        end
        s_axis_tvalid <= nv;
        s_axis_tdata  <= nd;
    end

    // stall the result side for a random count after each result
    always @(negedge aclk) begin : drain_results
        if (res_taken) begin
            if ($urandom_range(0, 99) < 2) m_calm = !m_calm;
            m_wait = m_calm ? 0 : $urandom_range(0, 10);
        end
        if (m_wait > 0) begin
            m_wait--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // queue one command and the ticks it needs to finish
    task automatic issue_cmd(input i2cmbs_pkg::op_t op, input logic [7:0] data,
                             input int n_high, input bit noisy);
        int              len;
        int              k;
        bit              timed_out;
        logic            s;
        i2cmbs_pkg::op_t o;
        timed_out = (op == i2cmbs_pkg::OP_WAIT) && (n_high > int'(ack_limit));
        case (op)
            i2cmbs_pkg::OP_START, i2cmbs_pkg::OP_ACK, i2cmbs_pkg::OP_NACK: len = 3;
            i2cmbs_pkg::OP_STOP:  len = 2;
            i2cmbs_pkg::OP_WRITE: len = 24;
            i2cmbs_pkg::OP_READ:  len = 16;
            i2cmbs_pkg::OP_WAIT:  len = timed_out ? int'(ack_limit) + 4 : n_high + 3;
            default:              len = 1;
        endcase
        for (k = 0; k < len; k++) begin
            o = (k == 0) ? op :
                (noisy ? i2cmbs_pkg::op_t'($urandom_range(0, 7)) : i2cmbs_pkg::OP_NONE);
            s = $urandom_range(0, 1);
            // read: present the byte MSB first on the sampling ticks
            if (op == i2cmbs_pkg::OP_READ && (k % 2) == 1) s = data[7 - k / 2];
            // wait ack: high polls, then low unless it gave up
            if (op == i2cmbs_pkg::OP_WAIT && k >= 2 && !(timed_out && k == len - 1))
                s = (k - 2 < n_high);
            pending_ticks.push_back({4'b0000, s,
                                     (k == 0) ? data : 8'($urandom_range(0, 255)), o});
        end
        if (op != i2cmbs_pkg::OP_NONE) stim_cnt += len;
    endtask

    function automatic int draw_polls();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    endfunction

    // well-formed transfers mostly, random command strings for the rest
    task automatic random_transfer();
        bit noisy;
        bit rd;
        int n;
        int i;
        noisy = $urandom_range(0, 1);
        if ($urandom_range(0, 4) != 0) begin
            issue_cmd(i2cmbs_pkg::OP_START, 8'($urandom_range(0, 255)), 0, noisy);
            issue_cmd(i2cmbs_pkg::OP_WRITE, 8'($urandom_range(0, 255)), 0, noisy);
            issue_cmd(i2cmbs_pkg::OP_WAIT, 8'($urandom_range(0, 255)), draw_polls(), noisy);
            n  = $urandom_range(1, 4);
            rd = $urandom_range(0, 1);
            for (i = 0; i < n; i++) begin
                if (rd) begin
                    issue_cmd(i2cmbs_pkg::OP_READ, 8'($urandom_range(0, 255)), 0, noisy);
                    issue_cmd((i == n - 1) ? i2cmbs_pkg::OP_NACK : i2cmbs_pkg::OP_ACK,
                              8'($urandom_range(0, 255)), 0, noisy);
                end else begin
                    issue_cmd(i2cmbs_pkg::OP_WRITE, 8'($urandom_range(0, 255)), 0, noisy);
                    issue_cmd(i2cmbs_pkg::OP_WAIT, 8'($urandom_range(0, 255)),
                              draw_polls(), noisy);
                end
            end
            issue_cmd(i2cmbs_pkg::OP_STOP, 8'($urandom_range(0, 255)), 0, noisy);
        end else begin
            repeat ($urandom_range(1, 4))
                issue_cmd(i2cmbs_pkg::op_t'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                          draw_polls(), noisy);
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                issue_cmd(i2cmbs_pkg::OP_NONE, 8'($urandom_range(0, 255)), 0, 0);
    endtask

    // hold until every request is sent and every result seen, plus latency
    task automatic settle_bus();
        while (pending_ticks.size() != 0 || s_axis_tvalid || expected_pins.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_limit(input logic [15:0] value);
        settle_bus();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        ack_limit = value;
        limit_writes++;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin : run_sequence
        int p;
        int stop_at;
        logic [15:0] lim;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset limit, every command, byte extremes, ops while busy
        issue_cmd(i2cmbs_pkg::OP_NONE, 8'hFF, 0, 0);
        issue_cmd(i2cmbs_pkg::OP_START, 8'h00, 0, 0);
        issue_cmd(i2cmbs_pkg::OP_WRITE, 8'h00, 0, 0);
        issue_cmd(i2cmbs_pkg::OP_WAIT, 8'h00, 0, 0);
        issue_cmd(i2cmbs_pkg::OP_WRITE, 8'hFF, 0, 0);
        issue_cmd(i2cmbs_pkg::OP_WAIT, 8'h00, 5, 0);
        issue_cmd(i2cmbs_pkg::OP_WRITE, 8'hA5, 0, 0);
        issue_cmd(i2cmbs_pkg::OP_START, 8'h00, 0, 0);
        issue_cmd(i2cmbs_pkg::OP_READ, 8'hFF, 0, 0);
        issue_cmd(i2cmbs_pkg::OP_ACK, 8'h00, 0, 0);
        issue_cmd(i2cmbs_pkg::OP_READ, 8'h00, 0, 0);
        issue_cmd(i2cmbs_pkg::OP_ACK, 8'h00, 0, 0);
        issue_cmd(i2cmbs_pkg::OP_READ, 8'h5A, 0, 0);
        issue_cmd(i2cmbs_pkg::OP_NACK, 8'h00, 0, 0);
        issue_cmd(i2cmbs_pkg::OP_STOP, 8'h00, 0, 0);
        issue_cmd(i2cmbs_pkg::OP_START, 8'h00, 0, 1);
        issue_cmd(i2cmbs_pkg::OP_WRITE, 8'h3C, 0, 1);
        issue_cmd(i2cmbs_pkg::OP_WAIT, 8'h00, 2, 1);
        issue_cmd(i2cmbs_pkg::OP_NACK, 8'h00, 0, 1);
        issue_cmd(i2cmbs_pkg::OP_STOP, 8'h00, 0, 1);

        // zero limit: one high sample gives up, a low one still acks
        set_limit(16'h0000);
        issue_cmd(i2cmbs_pkg::OP_WAIT, 8'h00, 2, 0);
        issue_cmd(i2cmbs_pkg::OP_WAIT, 8'h00, 0, 0);
        // full limit never gives up
        set_limit(16'hFFFF);
        issue_cmd(i2cmbs_pkg::OP_WAIT, 8'h00, 20, 0);
        // edge of a small limit
        set_limit(16'd3);
        issue_cmd(i2cmbs_pkg::OP_WAIT, 8'h00, 3, 0);
        issue_cmd(i2cmbs_pkg::OP_WAIT, 8'h00, 4, 0);

        // random phases, each under its own limit, sharing what is left
        for (p = 0; p < 6; p++) begin
            case (p)
                0: lim = 16'($urandom_range(1, 8));
                1: lim = i2cmbs_pkg::WAIT_MAX;
                2: lim = 16'($urandom_range(0, 65535));
                3: lim = 16'h0000;
                4: lim = 16'($urandom_range(2, 6));
                default: lim = i2cmbs_pkg::TIMEOUT_RESET;
            endcase
            set_limit(lim);
            stop_at = stim_cnt + (REQUEST_TARGET - stim_cnt) / (6 - p);
            while (stim_cnt < stop_at) random_transfer();
        end

        settle_bus();
        if (expected_pins.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_pins.size());
            err_cnt++;
        end
        $display("ran %0d ticks, checked %0d results under %0d limit settings",
                 req_cnt, res_cnt, limit_writes);
        $display("saw %0d completed reads and %0d ack wait timeouts", reads_done, timeouts_seen);
        if (err_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/i2cmbs_pkg.sv
rtl/core/i2c_master_bit_sequencer_unit.sv
tb/testbench.sv
